### hdl/rfms_pkg.sv
// Package with the mode, event and register codes and the reset values of the sequencer.
package rfms_pkg;

    typedef enum logic [3:0] {
        MODE_STANDBY    = 4'd0,
        MODE_READY      = 4'd1,
        MODE_POWERED    = 4'd2,
        MODE_FREE_CLIMB = 4'd3,
        MODE_DESCENT    = 4'd4,
        MODE_DROGUE     = 4'd5,
        MODE_MAIN       = 4'd6,
        MODE_LANDED     = 4'd7,
        MODE_SHUTDOWN   = 4'd8
    } t_mode;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_WAKEUP   = 4'd1,
        EV_IGNITION = 4'd2,
        EV_BURNOUT  = 4'd3,
        EV_APOGEE   = 4'd4,
        EV_SEP1     = 4'd5,
        EV_SEP2     = 4'd6,
        EV_LAND     = 4'd7,
        EV_SHUTDOWN = 4'd8
    } t_event;

    typedef enum logic [2:0] {
        REG_BURNOUT_MIN   = 3'd0,
        REG_SEP1          = 3'd1,
        REG_SEP2          = 3'd2,
        REG_LANDING       = 3'd3,
        REG_SHUTDOWN_DLY  = 3'd4,
        REG_MAIN_ALTITUDE = 3'd5
    } t_reg_idx;

    localparam int TIME_W  = 20;
    localparam int ALT_W   = 16;
    localparam int DT_W    = 10;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [TIME_W-1:0] RST_BURNOUT_MIN   = 20'd2000;
    localparam logic [TIME_W-1:0] RST_SEP1          = 20'd10000;
    localparam logic [TIME_W-1:0] RST_SEP2          = 20'd15000;
    localparam logic [TIME_W-1:0] RST_LANDING       = 20'd20000;
    localparam logic [TIME_W-1:0] RST_SHUTDOWN_DLY  = 20'd5000;
    localparam logic signed [ALT_W-1:0] RST_MAIN_ALTITUDE = 16'sd1000;

endpackage

### hdl/rocket_flight_mode_sequencer.sv
// Flight mode sequencer: input register, transition logic, result register and APB registers.
// A beat passes through the input register, then the result register.
// One beat per cycle unless the result stalls; the mode and timer update in the same cycle as
// the result register, so the next beat in the input register always sees the updated state.
// A stalled result holds the result register and, behind it, the input register.
// Synchronous active-low reset sets mode STANDBY, clears the timer and loads default thresholds.
module rocket_flight_mode_sequencer #(
    parameter int TIMER_BITS = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [rfms_pkg::DT_W-1:0]          i_elapsed_ms,
    input  logic                               i_flight_pin,
    input  logic                               i_force_negative,
    input  logic                               i_jerk_negative,
    input  logic                               i_falling,
    input  logic signed [rfms_pkg::ALT_W-1:0]  i_altitude_dm,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [3:0]                         o_mode,
    output logic [3:0]                         o_event_res,
    output logic [rfms_pkg::TIME_W-1:0]        o_flight_time_ms,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rfms_pkg::PADDR_W-1:0]       paddr,
    input  logic [rfms_pkg::PDATA_W-1:0]       pwdata,
    output logic [rfms_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int TW = rfms_pkg::TIME_W;
    localparam int CW = (TIMER_BITS > TW + 1) ? TIMER_BITS : TW + 1;

    logic [TW-1:0]                    r_burnout_min;
    logic [TW-1:0]                    r_sep1;
    logic [TW-1:0]                    r_sep2;
    logic [TW-1:0]                    r_landing;
    logic [TW-1:0]                    r_shutdown_dly;
    logic signed [rfms_pkg::ALT_W-1:0] r_main_alt;

    logic                             r_in_valid;
    logic [rfms_pkg::DT_W-1:0]        r_in_elapsed;
    logic                             r_in_pin;
    logic                             r_in_fneg;
    logic                             r_in_jneg;
    logic                             r_in_fall;
    logic signed [rfms_pkg::ALT_W-1:0] r_in_alt;

    rfms_pkg::t_mode                  r_mode;
    rfms_pkg::t_mode                  n_mode;
    logic [TIMER_BITS-1:0]            r_timer;
    logic [TIMER_BITS-1:0]            n_timer;
    rfms_pkg::t_event                 n_event;

    logic                             r_out_valid;
    rfms_pkg::t_mode                  r_out_mode;
    rfms_pkg::t_event                 r_out_event;
    logic [TW-1:0]                    r_out_time;
    logic [TW-1:0]                    n_out_time;

    logic                             out_free;
    logic                             advance;
    logic                             cfg_wr;
    rfms_pkg::t_reg_idx               cfg_idx;
    logic [TIMER_BITS:0]              timer_sum;
    logic [TIMER_BITS-1:0]            timer_sat;
    logic [CW-1:0]                    t_cmp;
    logic [CW-1:0]                    t_new_ext;
    logic [CW-1:0]                    shutdown_at;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cfg_idx    = rfms_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burnout_min  <= rfms_pkg::RST_BURNOUT_MIN;
            r_sep1         <= rfms_pkg::RST_SEP1;
            r_sep2         <= rfms_pkg::RST_SEP2;
            r_landing      <= rfms_pkg::RST_LANDING;
            r_shutdown_dly <= rfms_pkg::RST_SHUTDOWN_DLY;
            r_main_alt     <= rfms_pkg::RST_MAIN_ALTITUDE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rfms_pkg::REG_BURNOUT_MIN:   r_burnout_min  <= pwdata[TW-1:0];
                rfms_pkg::REG_SEP1:          r_sep1         <= pwdata[TW-1:0];
                rfms_pkg::REG_SEP2:          r_sep2         <= pwdata[TW-1:0];
                rfms_pkg::REG_LANDING:       r_landing      <= pwdata[TW-1:0];
                rfms_pkg::REG_SHUTDOWN_DLY:  r_shutdown_dly <= pwdata[TW-1:0];
                rfms_pkg::REG_MAIN_ALTITUDE: r_main_alt     <= pwdata[rfms_pkg::ALT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rfms_pkg::REG_BURNOUT_MIN:   prdata = rfms_pkg::PDATA_W'(r_burnout_min);
            rfms_pkg::REG_SEP1:          prdata = rfms_pkg::PDATA_W'(r_sep1);
            rfms_pkg::REG_SEP2:          prdata = rfms_pkg::PDATA_W'(r_sep2);
            rfms_pkg::REG_LANDING:       prdata = rfms_pkg::PDATA_W'(r_landing);
            rfms_pkg::REG_SHUTDOWN_DLY:  prdata = rfms_pkg::PDATA_W'(r_shutdown_dly);
            rfms_pkg::REG_MAIN_ALTITUDE: prdata = rfms_pkg::PDATA_W'(r_main_alt);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_elapsed <= i_elapsed_ms;
            r_in_pin     <= i_flight_pin;
            r_in_fneg    <= i_force_negative;
            r_in_jneg    <= i_jerk_negative;
            r_in_fall    <= i_falling;
            r_in_alt     <= i_altitude_dm;
        end
    end

    assign timer_sum   = {1'b0, r_timer} + (TIMER_BITS + 1)'(r_in_elapsed);
    assign timer_sat   = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
    assign t_cmp       = CW'(timer_sat);
    assign shutdown_at = CW'(r_landing) + CW'(r_shutdown_dly);

    always_comb begin
        n_mode  = r_mode;
        n_event = rfms_pkg::EV_NONE;
        n_timer = timer_sat;
        unique case (r_mode)
            rfms_pkg::MODE_STANDBY: begin
                if (r_in_pin) begin
                    n_mode  = rfms_pkg::MODE_READY;
                    n_event = rfms_pkg::EV_WAKEUP;
                end
            end
            rfms_pkg::MODE_READY: begin
                if (r_in_pin) begin
                    n_mode  = rfms_pkg::MODE_POWERED;
                    n_event = rfms_pkg::EV_IGNITION;
                    n_timer = '0;
                end
            end
            rfms_pkg::MODE_POWERED: begin
                if (t_cmp >= CW'(r_burnout_min) && r_in_fneg && r_in_jneg) begin
                    n_mode  = rfms_pkg::MODE_FREE_CLIMB;
                    n_event = rfms_pkg::EV_BURNOUT;
                end
            end
            rfms_pkg::MODE_FREE_CLIMB: begin
                if (r_in_fall) begin
                    n_mode  = rfms_pkg::MODE_DESCENT;
                    n_event = rfms_pkg::EV_APOGEE;
                end
            end
            rfms_pkg::MODE_DESCENT: begin
                if (t_cmp >= CW'(r_sep1)) begin
                    n_mode  = rfms_pkg::MODE_DROGUE;
                    n_event = rfms_pkg::EV_SEP1;
                end
            end
            rfms_pkg::MODE_DROGUE: begin
                if (t_cmp >= CW'(r_sep2) && r_in_alt < r_main_alt) begin
                    n_mode  = rfms_pkg::MODE_MAIN;
                    n_event = rfms_pkg::EV_SEP2;
                end
            end
            rfms_pkg::MODE_MAIN: begin
                if (t_cmp >= CW'(r_landing)) begin
                    n_mode  = rfms_pkg::MODE_LANDED;
                    n_event = rfms_pkg::EV_LAND;
                end
            end
            rfms_pkg::MODE_LANDED: begin
                if (t_cmp >= shutdown_at) begin
                    n_mode  = rfms_pkg::MODE_SHUTDOWN;
                    n_event = rfms_pkg::EV_SHUTDOWN;
                end
            end
            default: ;
        endcase
    end

    assign t_new_ext  = CW'(n_timer);
    assign n_out_time = (|t_new_ext[CW-1:TW]) ? '1 : t_new_ext[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rfms_pkg::MODE_STANDBY;
            r_timer <= '0;
        end else if (advance) begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_mode  <= n_mode;
            r_out_event <= n_event;
            r_out_time  <= n_out_time;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_out_mode;
    assign o_event_res      = r_out_event;
    assign o_flight_time_ms = r_out_time;

endmodule
